// ----- hw/rtl/scpe_pkg.sv -----
package scpe_pkg;

    // Time fraction bits (Q12.20 by default)
    localparam int TIME_FRAC_BITS = 20;

    // Port widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 120;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    // Segment numbers
    localparam logic [2:0] SEG_CRUISE = 3'd3;
    localparam logic [2:0] SEG_LAST   = 3'd6;

    // Sequencer steps: the two precompute steps, the first term, the only cruise term and the last term
    localparam logic [2:0] STEP_PRE_SQ   = 3'd0;
    localparam logic [2:0] STEP_PRE_CUBE = 3'd1;
    localparam logic [2:0] STEP_FIRST    = 3'd2;
    localparam logic [2:0] STEP_CRUISE   = 3'd5;
    localparam logic [2:0] STEP_LAST     = 3'd7;

    // Divide-by-three: 8 bits per cycle over 128 bits
    localparam logic [3:0] DIV_LAST_CNT = 4'd15;

    typedef enum logic [2:0] {
        REG_JERK_DUR   = 3'd0,
        REG_ACCEL_DUR  = 3'd1,
        REG_CRUISE_DUR = 3'd2,
        REG_START_POS  = 3'd3,
        REG_START_VEL  = 3'd4,
        REG_START_ACC  = 3'd5,
        REG_JERK_VAL   = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEG,
        ST_MAC,
        ST_RND,
        ST_DIV,
        ST_ACC,
        ST_SAT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        QTY_JERK,
        QTY_ACC,
        QTY_VEL,
        QTY_POS
    } qty_t;

    // Term table: coefficient source
    function automatic qty_t term_src(input logic [2:0] idx);
        qty_t r;
        case (idx)
            3'd1, 3'd4: r = QTY_ACC;
            3'd3:       r = QTY_VEL;
            default:    r = QTY_JERK;
        endcase
        return r;
    endfunction

    // Term table: power of the segment time
    function automatic logic [1:0] term_pow(input logic [2:0] idx);
        logic [1:0] r;
        case (idx)
            3'd2, 3'd4: r = 2'd2;
            3'd5:       r = 2'd3;
            default:    r = 2'd1;
        endcase
        return r;
    endfunction

    // Term table: quantity the term adds into
    function automatic qty_t term_dst(input logic [2:0] idx);
        qty_t r;
        case (idx)
            3'd0:       r = QTY_ACC;
            3'd1, 3'd2: r = QTY_VEL;
            default:    r = QTY_POS;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic [127:0] x);
        logic [31:0] r;
        if ((&x[127:31]) || !(|x[127:31]))
            r = x[31:0];
        else
            r = x[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return r;
    endfunction

    function automatic logic [47:0] sat48(input logic [127:0] x);
        logic [47:0] r;
        if ((&x[127:47]) || !(|x[127:47]))
            r = x[47:0];
        else
            r = x[127] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        return r;
    endfunction

endpackage

// ----- hw/rtl/scurve_profile_evaluator.sv -----
// Each sample walks the segments in order, up to the segment that holds the
// sample, through the SEG, MAC, RND, DIV (cubic term only), ACC and SAT states;
// the result register then loads in the DONE state.
// The next sample is accepted in the cycle after the result register loads; a
// single 32x32 multiply-accumulate unit and the divide-by-three of the cubic
// term set the pace. A stalled result holds the sequencer.
// Reset (rst_n low, asynchronous): all config registers clear to zero,
// sequencer returns to idle, no result pending.
module scurve_profile_evaluator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scpe_pkg::IN_TDATA_W-1:0]   s_tdata,   // [31:0] sample_time
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] accel_out, [63:32] velocity_out, [111:64] position_out,
    // [114:112] segment_out, [119:115] zero
    output logic [scpe_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic [scpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scpe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import scpe_pkg::*;

    // Configuration
    logic [31:0]  tj_reg, ta_reg, tv_reg;
    logic [47:0]  p0_reg;
    logic [31:0]  v0_reg, a0_reg, jr_reg;

    // Sequencer and datapath
    state_t       state_reg, state_next;
    logic [2:0]   k_reg;
    logic [31:0]  rem_reg;
    logic [31:0]  ts_reg;
    logic         full_reg;
    logic [32:0]  jseg_reg;
    logic [31:0]  a_reg, v_reg;
    logic [47:0]  p_reg;
    logic [63:0]  sq_reg;
    logic [95:0]  cube_reg;
    logic [2:0]   step_reg;
    logic [1:0]   limb_reg;
    logic [127:0] prod_reg;
    logic [127:0] val_reg;
    logic [1:0]   div_rem_reg;
    logic [3:0]   div_cnt_reg;
    logic [127:0] acc_a_reg, acc_v_reg, acc_p_reg;
    logic [OUT_TDATA_W-1:0] out_reg;
    logic         out_valid_reg;

    // Combinational helpers
    logic [34:0]  total;
    logic [31:0]  t_clamp;
    logic [31:0]  dur_k;
    logic         seg_full;
    logic         cruise;
    logic [32:0]  jseg_k;
    logic [2:0]   term_idx;
    qty_t         src, dst;
    logic [1:0]   pow;
    logic [32:0]  coef, coef_abs;
    logic         coef_neg;
    logic         is_pre;
    logic [31:0]  mac_mag;
    logic [1:0]   mac_pow;
    logic [95:0]  x96;
    logic [31:0]  xlimb;
    logic [63:0]  mul;
    logic [127:0] prod_add;
    logic         limb_last;
    logic [127:0] rnd_sh, rnd_val;
    logic [1:0]   div_r;
    logic [2:0]   div_cur;
    logic [7:0]   div_q;
    logic [127:0] sterm;
    logic         out_free;

    // Clamp the sample time to the profile end
    assign total   = ({3'b0, tj_reg} << 2) + ({3'b0, ta_reg} << 1) + {3'b0, tv_reg};
    assign t_clamp = ({3'b0, s_tdata[31:0]} > total) ? total[31:0] : s_tdata[31:0];

    // Duration and jerk of segment k
    always_comb
    begin
        case (k_reg)
            3'd1, 3'd5: dur_k = ta_reg;
            3'd3:       dur_k = tv_reg;
            default:    dur_k = tj_reg;
        endcase
        case (k_reg)
            3'd0, 3'd6: jseg_k = {jr_reg[31], jr_reg};
            3'd2, 3'd4: jseg_k = 33'd0 - {jr_reg[31], jr_reg};
            default:    jseg_k = 33'd0;
        endcase
    end

    assign seg_full = (k_reg != SEG_LAST) && (rem_reg >= dur_k);
    assign cruise   = (k_reg == SEG_CRUISE);

    // Term selection
    assign term_idx = step_reg - STEP_FIRST;
    assign src      = term_src(term_idx);
    assign dst      = term_dst(term_idx);
    assign pow      = term_pow(term_idx);

    always_comb
    begin
        case (src)
            QTY_ACC: coef = {a_reg[31], a_reg};
            QTY_VEL: coef = {v_reg[31], v_reg};
            default: coef = jseg_reg;
        endcase
    end

    assign coef_neg = coef[32];
    assign coef_abs = coef_neg ? (33'd0 - coef) : coef;
    assign is_pre   = (step_reg == STEP_PRE_SQ) || (step_reg == STEP_PRE_CUBE);

    // Operands of the shared multiply-accumulate unit
    always_comb
    begin
        mac_mag = is_pre ? ts_reg : coef_abs[31:0];
        if (step_reg == STEP_PRE_SQ)
        begin
            mac_pow = 2'd1;
            x96     = {64'd0, ts_reg};
        end
        else if (step_reg == STEP_PRE_CUBE)
        begin
            mac_pow = 2'd2;
            x96     = {32'd0, sq_reg};
        end
        else
        begin
            mac_pow = pow;
            case (pow)
                2'd2:    x96 = {32'd0, sq_reg};
                2'd3:    x96 = cube_reg;
                default: x96 = {64'd0, ts_reg};
            endcase
        end
    end

    assign xlimb     = x96[{limb_reg, 5'd0} +: 32];
    assign mul       = mac_mag * xlimb;
    assign prod_add  = prod_reg + ({64'd0, mul} << {limb_reg, 5'd0});
    assign limb_last = (limb_reg == (mac_pow - 2'd1));

    // Round the product onto the value grid
    always_comb
    begin
        case (pow)
            2'd2:    rnd_sh = prod_reg >> (2 * TIME_FRAC_BITS);
            2'd3:    rnd_sh = prod_reg >> (3 * TIME_FRAC_BITS);
            default: rnd_sh = prod_reg >> (TIME_FRAC_BITS - 1);
        endcase
        rnd_val = (rnd_sh + ((pow == 2'd3) ? 128'd3 : 128'd1)) >> 1;
    end

    // Divide by three, eight quotient bits per cycle
    always_comb
    begin
        div_r   = div_rem_reg;
        div_q   = 8'd0;
        div_cur = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            div_cur      = {div_r, val_reg[127 - i]};
            div_q[7 - i] = (div_cur >= 3'd3);
            div_r        = div_q[7 - i] ? 2'(div_cur - 3'd3) : div_cur[1:0];
        end
    end

    assign sterm    = coef_neg ? (128'd0 - val_reg) : val_reg;
    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_SEG;
            ST_SEG:  state_next = ST_MAC;
            ST_MAC:
            begin
                if (limb_last && !is_pre)
                    state_next = ST_RND;
            end
            ST_RND:  state_next = (pow == 2'd3) ? ST_DIV : ST_ACC;
            ST_DIV:  if (div_cnt_reg == DIV_LAST_CNT) state_next = ST_ACC;
            ST_ACC:  state_next = (cruise || step_reg == STEP_LAST) ? ST_SAT : ST_MAC;
            ST_SAT:  state_next = full_reg ? ST_SEG : ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = out_valid_reg;
        m_tdata  = out_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            tj_reg        <= '0;
            ta_reg        <= '0;
            tv_reg        <= '0;
            p0_reg        <= '0;
            v0_reg        <= '0;
            a0_reg        <= '0;
            jr_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_JERK_DUR:   tj_reg <= cfg_wdata[31:0];
                    REG_ACCEL_DUR:  ta_reg <= cfg_wdata[31:0];
                    REG_CRUISE_DUR: tv_reg <= cfg_wdata[31:0];
                    REG_START_POS:  p0_reg <= cfg_wdata[47:0];
                    REG_START_VEL:  v0_reg <= cfg_wdata[31:0];
                    REG_START_ACC:  a0_reg <= cfg_wdata[31:0];
                    REG_JERK_VAL:   jr_reg <= cfg_wdata[31:0];
                    default:        ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rem_reg <= t_clamp;
                    k_reg   <= 3'd0;
                    a_reg   <= a0_reg;
                    v_reg   <= v0_reg;
                    p_reg   <= p0_reg;
                end
            end
            ST_SEG:
            begin
                ts_reg    <= seg_full ? dur_k : rem_reg;
                full_reg  <= seg_full;
                jseg_reg  <= jseg_k;
                acc_a_reg <= {{96{a_reg[31]}}, a_reg};
                acc_v_reg <= {{96{v_reg[31]}}, v_reg};
                acc_p_reg <= {{80{p_reg[47]}}, p_reg};
                step_reg  <= STEP_PRE_SQ;
                limb_reg  <= 2'd0;
                prod_reg  <= '0;
            end
            ST_MAC:
            begin
                if (!limb_last)
                begin
                    prod_reg <= prod_add;
                    limb_reg <= limb_reg + 2'd1;
                end
                else
                begin
                    limb_reg <= 2'd0;
                    if (step_reg == STEP_PRE_SQ)
                    begin
                        sq_reg   <= prod_add[63:0];
                        step_reg <= STEP_PRE_CUBE;
                        prod_reg <= '0;
                    end
                    else if (step_reg == STEP_PRE_CUBE)
                    begin
                        cube_reg <= prod_add[95:0];
                        step_reg <= cruise ? STEP_CRUISE : STEP_FIRST;
                        prod_reg <= '0;
                    end
                    else
                        prod_reg <= prod_add;
                end
            end
            ST_RND:
            begin
                val_reg     <= rnd_val;
                div_cnt_reg <= 4'd0;
                div_rem_reg <= 2'd0;
            end
            ST_DIV:
            begin
                val_reg     <= {val_reg[119:0], div_q};
                div_rem_reg <= div_r;
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            ST_ACC:
            begin
                case (dst)
                    QTY_ACC: acc_a_reg <= acc_a_reg + sterm;
                    QTY_VEL: acc_v_reg <= acc_v_reg + sterm;
                    default: acc_p_reg <= acc_p_reg + sterm;
                endcase
                step_reg <= step_reg + 3'd1;
                prod_reg <= '0;
            end
            ST_SAT:
            begin
                a_reg <= sat32(acc_a_reg);
                v_reg <= sat32(acc_v_reg);
                p_reg <= sat48(acc_p_reg);
                if (full_reg)
                begin
                    rem_reg <= rem_reg - ts_reg;
                    k_reg   <= k_reg + 3'd1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    out_reg <= {5'd0, k_reg, p_reg, v_reg, a_reg};
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // A new sample always starts at segment 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_SEG && k_reg == 3'd0))
        else $error("sample did not start at segment 0");

    // Segment index never runs past the last segment
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAT) |-> (k_reg <= SEG_LAST))
        else $error("segment index out of range");

    // Only the cubic jerk term goes through the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (step_reg == STEP_LAST && !cruise))
        else $error("divider used outside cubic term");

    // A partial segment always delivers the sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAT && !full_reg) |=> (state_reg == ST_DONE))
        else $error("partial segment did not finish the sample");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import scpe_pkg::*;

    typedef struct packed {
        logic [2:0]  seg;
        logic [47:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
    } motion_t;

    typedef struct {
        int          cset;
        logic [31:0] t;
        bit          typed;
        motion_t     want;
    } row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;     // [31:0] sample_time
    logic m_tvalid;
    logic m_tready;
    // [31:0] accel, [63:32] velocity, [111:64] position, [114:112] segment
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic [47:0] profile_regs [7];
    motion_t     pending_motion [$];
    int          mismatches;
    int          burst_left;
    logic [47:0] cfg_sets [5][7];
    row_t        rows [$];

    scurve_profile_evaluator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // c * ts^n / d on the value grid, rounded half away from zero
    function automatic logic signed [127:0] poly_term(longint c, logic [63:0] ts,
                                                     int n, int d);
        logic [127:0] mag;
        logic [127:0] m;
        int s;
        mag = (c < 0) ? 128'(-c) : 128'(c);
        m = mag;
        repeat (n) m = m * {64'd0, ts};
        s = n * TIME_FRAC_BITS + ((d == 1) ? 0 : 1);
        m = (m >> (s - 1)) + ((d == 6) ? 128'd3 : 128'd1);
        m = m >> 1;
        if (d == 6)
            m = m / 3;
        return (c < 0) ? -$signed(m) : $signed(m);
    endfunction

    function automatic longint clip(logic signed [127:0] x, int w);
        logic signed [127:0] lim;
        lim = 128'sd1 <<< (w - 1);
        if (x > lim - 1)
            return longint'(lim - 1);
        if (x < -lim)
            return longint'(-lim);
        return longint'(x);
    endfunction

    // Closed form of one segment over ts
    function automatic void run_segment(int k, logic [63:0] ts, longint jr,
                                        inout longint a, inout longint v,
                                        inout longint p);
        longint j;
        longint na;
        longint nv;
        longint np;
        logic signed [127:0] wa;
        logic signed [127:0] wv;
        logic signed [127:0] wp;
        j = 0;
        if (k == 0 || k == 6)
            j = jr;
        else if (k == 2 || k == 4)
            j = -jr;
        wa = a;
        wv = v;
        wp = p;
        if (k == SEG_CRUISE)
        begin
            na = a;
            nv = v;
            np = clip(wp + poly_term(v, ts, 1, 1), 48);
        end
        else
        begin
            na = clip(wa + poly_term(j, ts, 1, 1), 32);
            nv = clip(wv + poly_term(a, ts, 1, 1) + poly_term(j, ts, 2, 2), 32);
            np = clip(wp + poly_term(v, ts, 1, 1) + poly_term(a, ts, 2, 2)
                      + poly_term(j, ts, 3, 6), 48);
        end
        a = na;
        v = nv;
        p = np;
    endfunction

    function automatic motion_t eval_profile(logic [31:0] t);
        logic [63:0] dur [7];
        logic [63:0] tj;
        logic [63:0] ta;
        logic [63:0] tv;
        logic [63:0] rem;
        longint a;
        longint v;
        longint p;
        longint jr;
        int k;
        motion_t r;
        tj = {32'd0, profile_regs[REG_JERK_DUR][31:0]};
        ta = {32'd0, profile_regs[REG_ACCEL_DUR][31:0]};
        tv = {32'd0, profile_regs[REG_CRUISE_DUR][31:0]};
        p = $signed(profile_regs[REG_START_POS]);
        v = $signed(profile_regs[REG_START_VEL][31:0]);
        a = $signed(profile_regs[REG_START_ACC][31:0]);
        jr = $signed(profile_regs[REG_JERK_VAL][31:0]);
        dur = '{tj, ta, tj, tv, tj, ta, tj};
        rem = {32'd0, t};
        if (rem > 4 * tj + 2 * ta + tv)
            rem = 4 * tj + 2 * ta + tv;
        k = 0;
        while (k < 6 && rem >= dur[k])
        begin
            run_segment(k, dur[k], jr, a, v, p);
            rem -= dur[k];
            k++;
        end
        run_segment(k, rem, jr, a, v, p);
        r.acc = a[31:0];
        r.vel = v[31:0];
        r.pos = p[47:0];
        r.seg = k[2:0];
        return r;
    endfunction

    // Register writes, only while the block is idle
    task automatic load_profile(input logic [47:0] vals [7]);
        while (pending_motion.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            profile_regs[i] = vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Send one sample in bursts; record expectation on the accepting edge
    task automatic send_sample(input logic [31:0] t, input bit typed,
                               input motion_t want);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= t;
        do
            @(posedge clk);
        while (!s_tready);
        pending_motion.push_back(typed ? want : eval_profile(t));
    endtask

    function automatic logic [47:0] rand_dur();
        case ($urandom_range(0, 9))
            0: return 48'd0;
            1: return {16'd0, $urandom()};
            2: return 48'($urandom_range(0, 16));
            default: return 48'($urandom_range(0, 32'h0020_0000));
        endcase
    endfunction

    function automatic logic [47:0] rand_val(int w);
        logic [47:0] x;
        x = {$urandom(), $urandom()};
        if ($urandom_range(0, 2) == 0)
            x = 48'($signed(x[20:0]));
        return (w == 48) ? x : 48'($signed(x[31:0]));
    endfunction

    // Receiver stalls in modes: always ready, random, mostly stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            case (($time / 2000) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        motion_t got;
        motion_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[114:0];
            if (pending_motion.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat %h", got);
            end
            else
            begin
                want = pending_motion.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: acc %h/%h vel %h/%h pos %h/%h seg %0d/%0d",
                                 want.acc, got.acc, want.vel, got.vel,
                                 want.pos, got.pos, want.seg, got.seg);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        logic [47:0] vals [7];
        logic [63:0] total;
        logic [31:0] t;
        logic [31:0] bound_times [11];
        motion_t zero_end;
        int cur;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        mismatches = 0;
        burst_left = 0;
        for (int i = 0; i < 7; i++)
            profile_regs[i] = '0;

        // Config sets for the directed part
        cfg_sets[0] = '{default: 48'd0};
        cfg_sets[1] = '{48'h10_0000, 48'h8_0000, 48'h4_0000, 48'h0000_0123_4000,
                        48'h0000_0002_0000, 48'hFFFF_FFFF_8000, 48'h0001_8000};
        cfg_sets[2] = '{48'hFFFF_FFFF, 48'hFFFF_FFFF, 48'hFFFF_FFFF,
                        48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF, 48'h7FFF_FFFF, 48'h7FFF_FFFF};
        cfg_sets[3] = '{48'd0, 48'd0, 48'h40_0000, 48'h8000_0000_0000,
                        48'hFFFF_8000_0000, 48'hFFFF_8000_0000, 48'hFFFF_8000_0000};
        cfg_sets[4] = '{48'd0, 48'h20_0000, 48'd7, 48'd0,
                        48'hFFFF_FFFF_0000, 48'h0003_0000, 48'hFFFF_8000_0000};

        // After reset: every time ends at the last segment at rest
        zero_end = '{seg: SEG_LAST, pos: '0, vel: '0, acc: '0};
        rows.push_back('{0, 32'd0, 1'b1, zero_end});
        rows.push_back('{0, 32'hFFFF_FFFF, 1'b1, zero_end});
        rows.push_back('{0, 32'h0001_2345, 1'b1, zero_end});
        // Segment boundaries of a small profile
        bound_times = '{32'd0, 32'd1048575, 32'd1048576, 32'd1572864,
                        32'd2621440, 32'd2883584, 32'd3932160,
                        32'd4456448, 32'd5505023, 32'd5505024,
                        32'hFFFF_FFFF};
        foreach (bound_times[i])
            rows.push_back('{1, bound_times[i], 1'b0, zero_end});
        // Saturating extremes, empty segments, tiny cruise
        rows.push_back('{2, 32'd0, 1'b0, zero_end});
        rows.push_back('{2, 32'h8000_0000, 1'b0, zero_end});
        rows.push_back('{2, 32'hFFFF_FFFF, 1'b0, zero_end});
        rows.push_back('{3, 32'd0, 1'b0, zero_end});
        rows.push_back('{3, 32'd1, 1'b0, zero_end});
        rows.push_back('{3, 32'hFFFF_FFFF, 1'b0, zero_end});
        rows.push_back('{4, 32'h20_0003, 1'b0, zero_end});
        rows.push_back('{4, 32'h40_0007, 1'b0, zero_end});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        cur = 0;
        foreach (rows[i])
        begin
            if (rows[i].cset != cur)
            begin
                s_tvalid <= 1'b0;
                cur = rows[i].cset;
                load_profile(cfg_sets[cur]);
            end
            send_sample(rows[i].t, rows[i].typed, rows[i].want);
        end

        // Random phases with fresh profiles
        for (int ph = 0; ph < 10; ph++)
        begin
            s_tvalid <= 1'b0;
            vals = '{rand_dur(), rand_dur(), rand_dur(), rand_val(48),
                     rand_val(32), rand_val(32), rand_val(32)};
            load_profile(vals);
            total = 4 * vals[0][31:0] + 2 * vals[1][31:0] + vals[2][31:0];
            for (int n = 0; n < 93; n++)
            begin
                if ($urandom_range(0, 9) < 3 || total == 0)
                    t = $urandom();
                else
                    t = 32'({$urandom(), $urandom()} % (total + 2));
                send_sample(t, 1'b0, zero_end);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_motion.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
